@@ rtl/rpi_pkg.sv @@
// Shared constants, types and helpers for the ray/parallelogram intersection block.
`timescale 1ns / 1ps
package rpi_pkg;

  // Number formats
  localparam int FRAC = 16;
  localparam int DATA_W = 32;
  localparam int COMP_W = 21;
  localparam int CFG_W = 3 * COMP_W;
  localparam int EPS_W = 16;
  localparam int IDX_W = 3;
  localparam int PROD_W = COMP_W + DATA_W;
  localparam int DOT_W = PROD_W + 2;
  localparam int D_W = DOT_W - FRAC;
  localparam int N_W = DOT_W + 1;
  localparam int Q_W = DATA_W;
  localparam int DIV_STAGES = Q_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PLANE_NORMAL = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIRST_AXIS = 3'd1;
  localparam logic [IDX_W-1:0] REG_SECOND_AXIS = 3'd2;
  localparam logic [IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
  localparam logic [IDX_W-1:0] REG_FIRST_OFFSET = 3'd4;
  localparam logic [IDX_W-1:0] REG_SECOND_OFFSET = 3'd5;
  localparam logic [IDX_W-1:0] REG_PARALLEL_EPS = 3'd6;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [CFG_W-1:0] normal;
    logic [CFG_W-1:0] axis1;
    logic [CFG_W-1:0] axis2;
    word_t poff;
    word_t off1;
    word_t off2;
    logic [EPS_W-1:0] eps;
  } cfg_t;

  typedef struct packed {
    word_t [2:0] org;
    word_t [2:0] dir;
    word_t near_l;
    word_t far_l;
  } ray_t;

  // Entry of the queue between front and back
  typedef struct packed {
    ray_t ray;
    logic par;
    logic signed [D_W-1:0] d;
    logic signed [N_W-1:0] n;
  } fq_t;

  // Side data that travels with each divide
  typedef struct packed {
    ray_t ray;
    logic par;
    logic neg;
  } dside_t;

  // One signed component of a packed three-component register.
  function automatic logic signed [COMP_W-1:0] comp(input logic [CFG_W-1:0] v,
                                                    input int k);
    comp = v[k*COMP_W +: COMP_W];
  endfunction

endpackage

@@ rtl/rpi_front.sv @@
// Front end: takes rays, forms the plane dot products, numerator and parallel flag.
`timescale 1ns / 1ps
module rpi_front import rpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ray_t in_ray,
  input  cfg_t cfg,
  output logic q_push,
  output fq_t  q_data,
  input  logic q_full
);

  logic adv;
  logic vld1_r, vld2_r;
  ray_t ray1_r;
  logic signed [PROD_W-1:0] pd_r [3];
  logic signed [PROD_W-1:0] po_r [3];
  fq_t q_r;
  logic signed [DOT_W-1:0] dotd, doto;
  logic signed [D_W-1:0] d;
  logic signed [D_W-1:0] eps;
  logic signed [N_W-1:0] n, offs;
  logic par;

  // The whole front moves when the queue has room.
  assign adv = !q_full;
  assign in_ready = adv;
  assign q_push = vld2_r && adv;
  assign q_data = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  // Stage 1: normal products with direction and origin.
  always_ff @(posedge clk) begin
    if (adv) begin
      ray1_r <= in_ray;
      for (int k = 0; k < 3; k++) begin
        pd_r[k] <= comp(cfg.normal, k) * $signed(in_ray.dir[k]);
        po_r[k] <= comp(cfg.normal, k) * $signed(in_ray.org[k]);
      end
    end
  end

  // Stage 2: sums, denominator, numerator and parallel test.
  always_comb begin
    dotd = DOT_W'(pd_r[0]) + DOT_W'(pd_r[1]) + DOT_W'(pd_r[2]);
    doto = DOT_W'(po_r[0]) + DOT_W'(po_r[1]) + DOT_W'(po_r[2]);
    d = dotd[DOT_W-1:FRAC];
    offs = N_W'($signed({cfg.poff, {FRAC{1'b0}}}));
    n = offs - N_W'(doto);
    eps = $signed({{(D_W-EPS_W){1'b0}}, cfg.eps});
    par = (d == '0) || ((d < eps) && (d > -eps));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r.ray <= ray1_r;
      q_r.par <= par;
      q_r.d <= d;
      q_r.n <= n;
    end
  end

endmodule

@@ rtl/rpi_fifo.sv @@
// Short queue that decouples the front end from the divide and projection back end.
`timescale 1ns / 1ps
module rpi_fifo import rpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  fq_t  wdata,
  output logic full,
  input  logic pop,
  output fq_t  rdata,
  output logic empty
);

  fq_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0] cnt_r;

  assign full = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ rtl/rpi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
module rpi_div import rpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  input  dside_t in_side,
  output logic out_vld,
  output logic [Q_W-1:0] quo,
  output logic ovf,
  output dside_t out_side
);

  localparam int W = D_W + Q_W;

  logic [DIV_STAGES-1:0] vld_r;
  logic [N_W-1:0] rem_r [DIV_STAGES];
  logic [D_W-1:0] den_r [DIV_STAGES];
  logic [Q_W-1:0] q_r [DIV_STAGES];
  logic ovf_r [DIV_STAGES];
  dside_t side_r [DIV_STAGES];

  logic [N_W-1:0] rem_in [DIV_STAGES];
  logic [D_W-1:0] den_in [DIV_STAGES];
  logic [Q_W-1:0] q_in [DIV_STAGES];
  logic [N_W-1:0] rem_nxt [DIV_STAGES];
  logic [Q_W-1:0] q_nxt [DIV_STAGES];
  logic [W-1:0] trial [DIV_STAGES];
  logic ovf_nxt;

  // A quotient of 2^Q_W or more saturates; flag it at the first stage.
  assign ovf_nxt = W'(num) >= {den, {Q_W{1'b0}}};

  // One compare and subtract per stage, most significant quotient bit first.
  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      rem_in[i] = (i == 0) ? num : rem_r[(i == 0) ? 0 : i-1];
      den_in[i] = (i == 0) ? den : den_r[(i == 0) ? 0 : i-1];
      q_in[i] = (i == 0) ? '0 : q_r[(i == 0) ? 0 : i-1];
      trial[i] = W'(den_in[i]) << (Q_W-1-i);
      q_nxt[i] = q_in[i];
      rem_nxt[i] = rem_in[i];
      if (W'(rem_in[i]) >= trial[i]) begin
        rem_nxt[i] = N_W'(W'(rem_in[i]) - trial[i]);
        q_nxt[i][Q_W-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_in[i];
        q_r[i] <= q_nxt[i];
        ovf_r[i] <= (i == 0) ? ovf_nxt : ovf_r[(i == 0) ? 0 : i-1];
        side_r[i] <= (i == 0) ? in_side : side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign quo = q_r[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule

@@ rtl/rpi_back.sv @@
// Back end: divide, limit test, hit point, edge projections and the output register.
`timescale 1ns / 1ps
module rpi_back import rpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  fq_t  q_data,
  output logic q_pop,
  input  cfg_t cfg,
  output logic out_valid,
  input  logic out_ready,
  output logic out_is_hit,
  output logic signed [DATA_W-1:0] out_hit_distance
);

  localparam int SUM_W = 2 * DATA_W - FRAC + 1;
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic adv;
  logic b0_vld_r, b2_vld_r, b3_vld_r, b4_vld_r, b5_vld_r;
  logic [N_W-1:0] nmag_r;
  logic [D_W-1:0] dmag_r;
  dside_t b0_side_r;
  logic dv_vld, dv_ovf;
  logic [Q_W-1:0] dv_q;
  dside_t dv_side;
  word_t t, t2_r, t3_r, t4_r, t5_r;
  logic miss, miss2_r, miss3_r, miss4_r, miss5_r;
  ray_t ray2_r, ray3_r;
  logic signed [2*DATA_W-1:0] dp_r [3];
  word_t p_r [3];
  word_t p_nxt [3];
  logic signed [SUM_W-1:0] psum [3];
  logic signed [PROD_W-1:0] a1_r [3];
  logic signed [PROD_W-1:0] a2_r [3];
  logic signed [N_W-1:0] u1, u2, one;
  logic hit;
  logic out_valid_r, out_hit_r;
  word_t out_dist_r;

  function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(WORD_MAX)) sat_word = WORD_MAX;
    else if (v < SUM_W'(WORD_MIN)) sat_word = WORD_MIN;
    else sat_word = DATA_W'(v);
  endfunction

  // All back stages move together when the output register is free or drained.
  assign adv = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      b3_vld_r <= 1'b0;
      b4_vld_r <= 1'b0;
      b5_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b0_vld_r <= !q_empty;
      b2_vld_r <= dv_vld;
      b3_vld_r <= b2_vld_r;
      b4_vld_r <= b3_vld_r;
      b5_vld_r <= b4_vld_r;
      out_valid_r <= b5_vld_r;
    end
  end

  // Operand magnitudes and quotient sign.
  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_r <= q_data.n[N_W-1] ? N_W'(-q_data.n) : N_W'(q_data.n);
      dmag_r <= q_data.d[D_W-1] ? D_W'(-q_data.d) : D_W'(q_data.d);
      b0_side_r.ray <= q_data.ray;
      b0_side_r.par <= q_data.par;
      b0_side_r.neg <= q_data.n[N_W-1] ^ q_data.d[D_W-1];
    end
  end

  rpi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (b0_vld_r),
    .num      (nmag_r),
    .den      (dmag_r),
    .in_side  (b0_side_r),
    .out_vld  (dv_vld),
    .quo      (dv_q),
    .ovf      (dv_ovf),
    .out_side (dv_side)
  );

  // Signed, saturated distance and the limit test.
  always_comb begin
    if (dv_ovf) t = dv_side.neg ? WORD_MIN : WORD_MAX;
    else if (!dv_side.neg) t = dv_q[Q_W-1] ? WORD_MAX : $signed(dv_q);
    else t = (dv_q > Q_W'(WORD_MIN)) ? WORD_MIN : $signed(-dv_q);
    miss = dv_side.par || (t > dv_side.ray.far_l) || (t < dv_side.ray.near_l);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_r <= t;
      miss2_r <= miss;
      ray2_r <= dv_side.ray;
    end
  end

  // Direction times distance.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dp_r[k] <= $signed(ray2_r.dir[k]) * t2_r;
      end
      t3_r <= t2_r;
      miss3_r <= miss2_r;
      ray3_r <= ray2_r;
    end
  end

  // Hit point, saturated per component.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = SUM_W'($signed(ray3_r.org[k])) + SUM_W'(dp_r[k] >>> FRAC);
      p_nxt[k] = sat_word(psum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
      t4_r <= t3_r;
      miss4_r <= miss3_r;
    end
  end

  // Edge axis products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a1_r[k] <= comp(cfg.axis1, k) * p_r[k];
        a2_r[k] <= comp(cfg.axis2, k) * p_r[k];
      end
      t5_r <= t4_r;
      miss5_r <= miss4_r;
    end
  end

  // Both edge coordinates must lie in the closed unit range.
  always_comb begin
    one = N_W'(1) << (2 * FRAC);
    u1 = N_W'(a1_r[0]) + N_W'(a1_r[1]) + N_W'(a1_r[2])
       - N_W'($signed({cfg.off1, {FRAC{1'b0}}}));
    u2 = N_W'(a2_r[0]) + N_W'(a2_r[1]) + N_W'(a2_r[2])
       - N_W'($signed({cfg.off2, {FRAC{1'b0}}}));
    hit = !miss5_r && (u1 >= 0) && (u1 <= one) && (u2 >= 0) && (u2 <= one);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= hit;
      out_dist_r <= hit ? t5_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_is_hit = out_hit_r;
  assign out_hit_distance = out_dist_r;

endmodule

@@ rtl/ray_parallelogram_intersect.sv @@
// Top level of the ray/parallelogram intersection block with its configuration registers.
//
// Usage: rays enter on the in_ channel (valid/ready); one result per ray leaves on
// the out_ channel (valid/ready) in the same order. The cfg_ channel writes the
// parallelogram registers by index; cfg_ready is always high and writes to an index
// beyond the register list are dropped. Write configuration only while idle.
// Throughput is one ray per cycle while the out_ side does not stall. With the queue
// empty, a ray passes the input stage (loaded at the transfer edge) and one more
// front stage, the queue, one operand stage, 32 divider stages (one quotient bit
// each) and five projection/output stages. Most of the pipeline is the divider.
// A stall on the out_ side freezes the back end; the four-entry queue keeps the
// front end taking rays until it fills, then in_ready drops.
// Synchronous active-low reset empties the pipeline and queue, clears the
// configuration registers to zero and sets parallel_epsilon to one.
`timescale 1ns / 1ps
module ray_parallelogram_intersect import rpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [DATA_W-1:0] in_origin_x,
  input  logic signed [DATA_W-1:0] in_origin_y,
  input  logic signed [DATA_W-1:0] in_origin_z,
  input  logic signed [DATA_W-1:0] in_direction_x,
  input  logic signed [DATA_W-1:0] in_direction_y,
  input  logic signed [DATA_W-1:0] in_direction_z,
  input  logic signed [DATA_W-1:0] in_near_limit,
  input  logic signed [DATA_W-1:0] in_far_limit,
  output logic out_valid,
  input  logic out_ready,
  output logic out_is_hit,
  output logic signed [DATA_W-1:0] out_hit_distance,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg_r;
  ray_t in_ray;
  logic q_push, q_pop, q_full, q_empty;
  fq_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{normal: '0, axis1: '0, axis2: '0, poff: '0, off1: '0, off2: '0,
                 eps: EPS_W'(1)};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PLANE_NORMAL:  cfg_r.normal <= cfg_data;
        REG_FIRST_AXIS:    cfg_r.axis1 <= cfg_data;
        REG_SECOND_AXIS:   cfg_r.axis2 <= cfg_data;
        REG_PLANE_OFFSET:  cfg_r.poff <= cfg_data[DATA_W-1:0];
        REG_FIRST_OFFSET:  cfg_r.off1 <= cfg_data[DATA_W-1:0];
        REG_SECOND_OFFSET: cfg_r.off2 <= cfg_data[DATA_W-1:0];
        REG_PARALLEL_EPS:  cfg_r.eps <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_ray.org[0] = in_origin_x;
    in_ray.org[1] = in_origin_y;
    in_ray.org[2] = in_origin_z;
    in_ray.dir[0] = in_direction_x;
    in_ray.dir[1] = in_direction_y;
    in_ray.dir[2] = in_direction_z;
    in_ray.near_l = in_near_limit;
    in_ray.far_l = in_far_limit;
  end

  rpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ray   (in_ray),
    .cfg      (cfg_r),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  rpi_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rpi_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_hit       (out_is_hit),
    .out_hit_distance (out_hit_distance)
  );

endmodule
